// File: design/sfsktg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed FSK tone generator package
// Fixed widths, reset values, register indexes, state codes and the
// quarter-wave sine function that fills the sine table at elaboration.
// ----------------------------------------------------------------------------
package sfsktg_pkg;

    // Field and register widths.
    localparam int TONE_BITS    = 3;
    localparam int BASE_BITS    = 31;
    localparam int TSTEP_BITS   = 28;
    localparam int ALPHA_BITS   = 16;
    localparam int AMP_BITS     = 15;
    localparam int SAMPLE_BITS  = 16;
    localparam int STEP_BITS    = 40;
    localparam int SINE_MAG_BITS = 15;
    localparam int MUL_CNT_BITS = $clog2(ALPHA_BITS);

    // Register reset values.
    localparam logic [BASE_BITS-1:0]  BASE_STEP_RST = 31'd357913941;
    localparam logic [TSTEP_BITS-1:0] TONE_STEP_RST = 28'd2236962;
    localparam logic [ALPHA_BITS-1:0] ALPHA_RST     = 16'd1966;
    localparam logic [AMP_BITS-1:0]   AMP_RST       = 15'd16384;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_BASE_STEP = 2'd0;
    localparam logic [1:0] REG_TONE_STEP = 2'd1;
    localparam logic [1:0] REG_ALPHA     = 2'd2;
    localparam logic [1:0] REG_AMPLITUDE = 2'd3;

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TGT   = 3'd1;
    localparam logic [2:0] ST_DIFF  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_PHASE = 3'd5;
    localparam logic [2:0] ST_SINE  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    // Q30 product, truncated toward zero.
    function automatic longint mul_q30(input longint a, input longint b);
        logic neg;
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned r;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        r = (ua * ub) >> 30;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // Sine of a quarter-wave position, Q15 magnitude from a 9th order
    // Taylor series in Q30. Used only with constant arguments.
    function automatic logic [SINE_MAG_BITS-1:0] quarter_sine(input int unsigned pos,
                                                             input int unsigned qbits);
        longint x;
        longint x2;
        longint p;
        longint v;
        x  = longint'(pos) << (30 - qbits);
        x2 = mul_q30(x, x);
        p  = 172272;
        p  = -5026997 + mul_q30(p, x2);
        p  = 85569305 + mul_q30(p, x2);
        p  = -693598669 + mul_q30(p, x2);
        p  = 1686629713 + mul_q30(p, x2);
        p  = mul_q30(p, x);
        if (p < 0)
        begin
            p = 0;
        end
        v = (p + 16384) >>> 15;
        if (v > 32767)
        begin
            v = 32767;
        end
        return v[SINE_MAG_BITS-1:0];
    endfunction

endpackage

// File: design/smoothed_fsk_tone_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed FSK tone generator core
// Numerically controlled oscillator with a smoothed frequency step, a
// quarter-symmetric sine table and amplitude scaling.
// ----------------------------------------------------------------------------
// Each request is one sample tick and gives one sample. An active tick that
// smooths the step is finished before the next tick is accepted: the alpha
// product runs bit-serially through a shift-and-add multiplier, followed by
// the step update, the phase add, the table read and the amplitude product.
// A start tick skips the multiplier; an inactive tick skips the whole
// datapath and gives zero. The finished sample waits in an output register,
// so the next tick is taken while it is still held. Configuration writes are
// taken at any time but must only happen while the block is idle.

module smoothed_fsk_tone_generator_core #(
    parameter int SINE_ADDR_BITS = 10,
    parameter int PHASE_BITS     = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Tick input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [sfsktg_pkg::TONE_BITS-1:0] tone,
    input  logic        active,
    input  logic        start_req,
    // Sample output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [sfsktg_pkg::SAMPLE_BITS-1:0] sample
);

    localparam int QBITS = SINE_ADDR_BITS - 2;
    localparam int QLEN  = 1 << QBITS;
    localparam int POS_W = QBITS + 1;
    localparam int SB    = sfsktg_pkg::STEP_BITS;
    localparam int MCW   = sfsktg_pkg::MUL_CNT_BITS;

    // Configuration registers
    logic [sfsktg_pkg::BASE_BITS-1:0]  base_step_reg;
    logic [sfsktg_pkg::TSTEP_BITS-1:0] tone_step_reg;
    logic [sfsktg_pkg::ALPHA_BITS-1:0] smooth_alpha_reg;
    logic [sfsktg_pkg::AMP_BITS-1:0]   amplitude_reg;
    logic cfg_write;

    // Sequencer and datapath registers
    logic [2:0]      state_reg, state_next;
    logic [sfsktg_pkg::TONE_BITS-1:0] tone_reg, tone_next;
    logic            active_reg, active_next;
    logic            start_reg, start_next;
    logic [SB-1:0]   target_reg, target_next;
    logic [SB-1:0]   step_reg, step_next;
    logic [SB-1:0]   diff_reg, diff_next;
    logic            up_reg, up_next;
    logic [SB-1:0]   acc_reg, acc_next;
    logic            sticky_reg, sticky_next;
    logic [sfsktg_pkg::ALPHA_BITS-1:0] alpha_sh_reg, alpha_sh_next;
    logic [MCW-1:0]  cnt_reg, cnt_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [sfsktg_pkg::SINE_MAG_BITS-1:0] mag_reg, mag_next;
    logic            neg_reg, neg_next;
    logic            out_valid_reg, out_valid_next;
    logic [sfsktg_pkg::SAMPLE_BITS-1:0] sample_reg, sample_next;

    // Combinational helpers
    logic [30:0]     tone_prod;
    logic [31:0]     tone_sum;
    logic [SB:0]     mul_sum;
    logic [PHASE_BITS-1:0] phase_inc;
    logic [SINE_ADDR_BITS-1:0] sine_addr;
    logic [POS_W-1:0] sine_pos;
    logic [sfsktg_pkg::SINE_MAG_BITS-1:0] qtab [QLEN+1];
    logic [29:0]     amp_prod;
    logic [30:0]     amp_round;
    logic [sfsktg_pkg::SAMPLE_BITS-1:0] amp_mag;

    // Configuration write and read
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_step_reg    <= sfsktg_pkg::BASE_STEP_RST;
            tone_step_reg    <= sfsktg_pkg::TONE_STEP_RST;
            smooth_alpha_reg <= sfsktg_pkg::ALPHA_RST;
            amplitude_reg    <= sfsktg_pkg::AMP_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                sfsktg_pkg::REG_BASE_STEP:
                    base_step_reg <= pwdata[sfsktg_pkg::BASE_BITS-1:0];
                sfsktg_pkg::REG_TONE_STEP:
                    tone_step_reg <= pwdata[sfsktg_pkg::TSTEP_BITS-1:0];
                sfsktg_pkg::REG_ALPHA:
                    smooth_alpha_reg <= pwdata[sfsktg_pkg::ALPHA_BITS-1:0];
                sfsktg_pkg::REG_AMPLITUDE:
                    amplitude_reg <= pwdata[sfsktg_pkg::AMP_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            sfsktg_pkg::REG_BASE_STEP: prdata = 32'(base_step_reg);
            sfsktg_pkg::REG_TONE_STEP: prdata = 32'(tone_step_reg);
            sfsktg_pkg::REG_ALPHA:     prdata = 32'(smooth_alpha_reg);
            sfsktg_pkg::REG_AMPLITUDE: prdata = 32'(amplitude_reg);
            default:                   prdata = '0;
        endcase
    end

    // Quarter-wave sine table, one extra entry for the peak.
    for (genvar gi = 0; gi <= QLEN; gi++)
    begin : g_qtab
        assign qtab[gi] = sfsktg_pkg::quarter_sine(gi, QBITS);
    end

    // Phase increment is the step aligned to the phase accumulator.
    if (PHASE_BITS <= SB)
    begin : g_inc_shr
        assign phase_inc = step_reg[SB-1 -: PHASE_BITS];
    end
    else
    begin : g_inc_shl
        assign phase_inc = {step_reg, {(PHASE_BITS-SB){1'b0}}};
    end

    // Target step, serial multiplier adder, table address and output scaling.
    assign tone_prod = 31'(tone_reg) * 31'(tone_step_reg);
    assign tone_sum  = {1'b0, base_step_reg} + {1'b0, tone_prod};
    assign mul_sum   = {1'b0, acc_reg} + (alpha_sh_reg[0] ? {1'b0, diff_reg} : '0);
    assign sine_addr = phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign sine_pos  = sine_addr[SINE_ADDR_BITS-2]
                       ? (POS_W'(QLEN) - {1'b0, sine_addr[QBITS-1:0]})
                       : {1'b0, sine_addr[QBITS-1:0]};
    assign amp_prod  = 30'(amplitude_reg) * 30'(mag_reg);
    assign amp_round = {1'b0, amp_prod} + 31'd16384;
    assign amp_mag   = amp_round[30:15];

    // Handshake outputs
    assign in_ready  = (state_reg == sfsktg_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // Sequencer next-state logic
    always_comb
    begin
        state_next     = state_reg;
        tone_next      = tone_reg;
        active_next    = active_reg;
        start_next     = start_reg;
        target_next    = target_reg;
        step_next      = step_reg;
        diff_next      = diff_reg;
        up_next        = up_reg;
        acc_next       = acc_reg;
        sticky_next    = sticky_reg;
        alpha_sh_next  = alpha_sh_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sfsktg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    tone_next   = tone;
                    active_next = active;
                    start_next  = start_req;
                    state_next  = active ? sfsktg_pkg::ST_TGT : sfsktg_pkg::ST_OUT;
                end
            end
            sfsktg_pkg::ST_TGT:
            begin
                target_next = {tone_sum, 8'd0};
                state_next  = sfsktg_pkg::ST_DIFF;
            end
            sfsktg_pkg::ST_DIFF:
            begin
                if (start_reg)
                begin
                    step_next  = target_reg;
                    state_next = sfsktg_pkg::ST_PHASE;
                end
                else
                begin
                    up_next       = (target_reg >= step_reg);
                    diff_next     = (target_reg >= step_reg) ? (target_reg - step_reg)
                                                             : (step_reg - target_reg);
                    acc_next      = '0;
                    sticky_next   = 1'b0;
                    alpha_sh_next = smooth_alpha_reg;
                    cnt_next      = '0;
                    state_next    = sfsktg_pkg::ST_MUL;
                end
            end
            sfsktg_pkg::ST_MUL:
            begin
                // One alpha bit per cycle; low product bits fold into sticky.
                acc_next      = mul_sum[SB:1];
                sticky_next   = sticky_reg | mul_sum[0];
                alpha_sh_next = alpha_sh_reg >> 1;
                cnt_next      = cnt_reg + MCW'(1);
                if (cnt_reg == MCW'(sfsktg_pkg::ALPHA_BITS - 1))
                begin
                    state_next = sfsktg_pkg::ST_UPD;
                end
            end
            sfsktg_pkg::ST_UPD:
            begin
                // Rising steps round down, falling steps round the delta up.
                if (up_reg)
                begin
                    step_next = step_reg + acc_reg;
                end
                else
                begin
                    step_next = step_reg - acc_reg - SB'(sticky_reg);
                end
                state_next = sfsktg_pkg::ST_PHASE;
            end
            sfsktg_pkg::ST_PHASE:
            begin
                phase_next = phase_reg + phase_inc;
                state_next = sfsktg_pkg::ST_SINE;
            end
            sfsktg_pkg::ST_SINE:
            begin
                mag_next   = qtab[sine_pos];
                neg_next   = sine_addr[SINE_ADDR_BITS-1];
                state_next = sfsktg_pkg::ST_OUT;
            end
            sfsktg_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (!active_reg)
                    begin
                        sample_next = '0;
                    end
                    else if (neg_reg)
                    begin
                        sample_next = -amp_mag;
                    end
                    else
                    begin
                        sample_next = amp_mag;
                    end
                    state_next = sfsktg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sfsktg_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and oscillator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfsktg_pkg::ST_IDLE;
            step_reg      <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tone_reg     <= tone_next;
        active_reg   <= active_next;
        start_reg    <= start_next;
        target_reg   <= target_next;
        diff_reg     <= diff_next;
        up_reg       <= up_next;
        acc_reg      <= acc_next;
        sticky_reg   <= sticky_next;
        alpha_sh_reg <= alpha_sh_next;
        cnt_reg      <= cnt_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        sample_reg   <= sample_next;
    end

endmodule

// File: design/sfsktg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed FSK tone generator port checker
// Watches the top-level ports for handshake and output range errors.
// ----------------------------------------------------------------------------
module sfsktg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic signed [sfsktg_pkg::SAMPLE_BITS-1:0] sample
);

    // A stalled sample stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample))
        else $error("output sample changed while stalled");

    // Once a tick is taken, the block is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("tick accepted on consecutive cycles");

    // A clock edge in reset leaves the output empty and the input side ready.
    a_reset_state: assert property (@(posedge clk)
        !rst_n |=> !out_valid && in_ready)
        else $error("wrong port state after reset");

    // The scaled sine never reaches the negative full-scale code.
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample != 16'sh8000)
        else $error("sample outside symmetric range");

endmodule

bind smoothed_fsk_tone_generator_core sfsktg_checker u_sfsktg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed FSK tone generator testbench
// Drives sample ticks and register writes into the tone generator core.
// A built-in NCO predictor models the expected sample of every accepted
// request. A short table of directed ticks runs first. Random symbol-shaped
// tick sequences follow under several register settings and handshake
// idling patterns. Every returned sample is compared with the prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LUT_ADDR_BITS = 10;
    localparam int PHASE_W       = 32;
    localparam int LUT_SIZE      = 1 << LUT_ADDR_BITS;
    localparam int QUARTER_BITS  = LUT_ADDR_BITS - 2;
    localparam int QUARTER_LEN   = 1 << QUARTER_BITS;
    localparam int MAX_REPORTS   = 10;
    localparam int ITEMS_PER_SET = 125;
    localparam int SETTING_COUNT = 8;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [1:0]             reg_idx;
        logic [31:0]            wdata;
        logic [sfsktg_pkg::TONE_BITS-1:0] tone;
        logic                   active;
        logic                   start;
        bit                     typed;
        logic signed [sfsktg_pkg::SAMPLE_BITS-1:0] sample;
    } row_t;

    // Block inputs, all known from time zero.
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   psel      = 1'b0;
    logic                   penable   = 1'b0;
    logic                   pwrite    = 1'b0;
    logic [3:0]             paddr     = '0;
    logic [31:0]            pwdata    = '0;
    logic                   in_valid  = 1'b0;
    logic [sfsktg_pkg::TONE_BITS-1:0] tone = '0;
    logic                   active    = 1'b0;
    logic                   start_req = 1'b0;
    logic                   out_ready = 1'b0;

    // Block outputs.
    logic [31:0]            prdata;
    logic                   pready;
    logic                   in_ready;
    logic                   out_valid;
    logic signed [sfsktg_pkg::SAMPLE_BITS-1:0] sample;

    // Predictor state and register shadows.
    int                     sine_lut [LUT_SIZE];
    logic [sfsktg_pkg::BASE_BITS-1:0]  shadow_base;
    logic [sfsktg_pkg::TSTEP_BITS-1:0] shadow_tstep;
    logic [sfsktg_pkg::ALPHA_BITS-1:0] shadow_alpha;
    logic [sfsktg_pkg::AMP_BITS-1:0]   shadow_amp;
    logic [sfsktg_pkg::STEP_BITS-1:0]  step_q;
    logic [PHASE_W-1:0]     phase_q;

    logic signed [sfsktg_pkg::SAMPLE_BITS-1:0] pending_samples [$];
    logic signed [sfsktg_pkg::SAMPLE_BITS-1:0] want_sample;
    int                     mismatch_count = 0;
    int                     sender_idle_pct = 0;
    int                     receiver_stall_pct = 0;
    row_t                   directed_rows [$];

    smoothed_fsk_tone_generator_core #(
        .SINE_ADDR_BITS (LUT_ADDR_BITS),
        .PHASE_BITS     (PHASE_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .tone      (tone),
        .active    (active),
        .start_req (start_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample)
    );

    // 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Q30 product with truncation toward zero.
    function automatic longint q30_product(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned r;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        r = (ma * mb) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // Q15 sine magnitude of a quarter-wave position, odd Taylor series in Q30.
    function automatic int quarter_wave_q15(input int unsigned pos);
        longint x;
        longint xsq;
        longint acc;
        x = longint'(pos) << (30 - QUARTER_BITS);
        xsq = q30_product(x, x);
        acc = 172272;
        acc = q30_product(acc, xsq) - 5026997;
        acc = q30_product(acc, xsq) + 85569305;
        acc = q30_product(acc, xsq) - 693598669;
        acc = q30_product(acc, xsq) + 1686629713;
        acc = q30_product(acc, x);
        if (acc < 0)
        begin
            acc = 0;
        end
        acc = (acc + 16384) >>> 15;
        return (acc > 32767) ? 32767 : int'(acc);
    endfunction

    // Advances the oscillator by one tick and returns the sample it gives.
    function automatic logic signed [sfsktg_pkg::SAMPLE_BITS-1:0] next_sample(
        input logic [sfsktg_pkg::TONE_BITS-1:0] t, input logic act, input logic st);
        logic [63:0] target;
        logic [63:0] gap;
        logic [63:0] mag;
        int s;
        if (!act)
        begin
            return '0;
        end
        target = (64'(shadow_base) + 64'(t) * 64'(shadow_tstep)) << 8;
        if (st)
        begin
            step_q = target[sfsktg_pkg::STEP_BITS-1:0];
        end
        else if (target >= 64'(step_q))
        begin
            gap = target - 64'(step_q);
            step_q = step_q + sfsktg_pkg::STEP_BITS'((64'(shadow_alpha) * gap) >> 16);
        end
        else
        begin
            // Moving down rounds the step toward the target.
            gap = 64'(step_q) - target;
            step_q = step_q
                     - sfsktg_pkg::STEP_BITS'((64'(shadow_alpha) * gap + 64'd65535) >> 16);
        end
        phase_q = phase_q + step_q[sfsktg_pkg::STEP_BITS-1 -: PHASE_W];
        s = sine_lut[phase_q[PHASE_W-1 -: LUT_ADDR_BITS]];
        mag = (64'(shadow_amp) * 64'((s < 0) ? -s : s) + 64'd16384) >> 15;
        return (s < 0) ? -mag[sfsktg_pkg::SAMPLE_BITS-1:0] : mag[sfsktg_pkg::SAMPLE_BITS-1:0];
    endfunction

    function automatic row_t tick_row(input logic [sfsktg_pkg::TONE_BITS-1:0] t,
                                      input logic act, input logic st);
        row_t r;
        r = '{kind: ROW_TICK, reg_idx: '0, wdata: '0, tone: t, active: act, start: st,
              typed: 1'b0, sample: '0};
        return r;
    endfunction

    // Tick whose sample is known to be zero without running the predictor.
    function automatic row_t zero_row(input logic [sfsktg_pkg::TONE_BITS-1:0] t,
                                      input logic act, input logic st);
        row_t r;
        r = tick_row(t, act, st);
        r.typed = 1'b1;
        return r;
    endfunction

    function automatic row_t write_row(input logic [1:0] idx, input logic [31:0] data);
        row_t r;
        r = tick_row('0, 1'b0, 1'b0);
        r.kind = ROW_WRITE;
        r.reg_idx = idx;
        r.wdata = data;
        return r;
    endfunction

    // Register value for a random setting: zero, all ones, or random bits.
    function automatic logic [31:0] pick_reg_value();
        case ($urandom_range(3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Presents one tick request, waits for acceptance and records its sample.
    task automatic send_tick(input logic [sfsktg_pkg::TONE_BITS-1:0] t, input logic act,
                             input logic st, input bit typed,
                             input logic signed [sfsktg_pkg::SAMPLE_BITS-1:0] typed_sample);
        logic signed [sfsktg_pkg::SAMPLE_BITS-1:0] predicted;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        tone      <= t;
        active    <= act;
        start_req <= st;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predicted = next_sample(t, act, st);
        pending_samples.push_back(typed ? typed_sample : predicted);
    endtask

    // Drops valid and lets every outstanding sample come back.
    task automatic drain_ticks();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Register write through setup and access cycles, only while idle.
    task automatic program_register(input logic [1:0] idx, input logic [31:0] data);
        drain_ticks();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        case (idx)
            sfsktg_pkg::REG_BASE_STEP: shadow_base  = data[sfsktg_pkg::BASE_BITS-1:0];
            sfsktg_pkg::REG_TONE_STEP: shadow_tstep = data[sfsktg_pkg::TSTEP_BITS-1:0];
            sfsktg_pkg::REG_ALPHA:     shadow_alpha = data[sfsktg_pkg::ALPHA_BITS-1:0];
            sfsktg_pkg::REG_AMPLITUDE: shadow_amp   = data[sfsktg_pkg::AMP_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver stalls at random according to the current pattern.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Compare each returned sample with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_samples.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("ERROR: sample %0d returned with no request pending", sample);
                end
            end
            else
            begin
                want_sample = pending_samples.pop_front();
                if (sample !== want_sample)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("ERROR: sample mismatch at %0t: expected %0d, got %0d",
                                 $realtime, want_sample, sample);
                    end
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        int unsigned quad;
        int unsigned k;
        int unsigned pos;
        int mag;
        int counted;
        int run_len;
        int roll;
        logic [sfsktg_pkg::TONE_BITS-1:0] sym_tone;
        logic [sfsktg_pkg::TONE_BITS-1:0] rnd_tone;
        logic rnd_act;

        // Sine table, quarter-wave symmetric.
        for (int a = 0; a < LUT_SIZE; a++)
        begin
            quad = (a >> QUARTER_BITS) & 3;
            k = a & (QUARTER_LEN - 1);
            pos = (quad & 1) ? (QUARTER_LEN - k) : k;
            mag = quarter_wave_q15(pos);
            sine_lut[a] = (quad & 2) ? -mag : mag;
        end

        shadow_base  = sfsktg_pkg::BASE_STEP_RST;
        shadow_tstep = sfsktg_pkg::TONE_STEP_RST;
        shadow_alpha = sfsktg_pkg::ALPHA_RST;
        shadow_amp   = sfsktg_pkg::AMP_RST;
        step_q       = '0;
        phase_q      = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed ticks: silence, start loads, smoothing both ways,
        // alpha and amplitude extremes, maximum and zero steps.
        directed_rows.push_back(zero_row(3'd7, 1'b0, 1'b1));
        directed_rows.push_back(tick_row(3'd0, 1'b1, 1'b0));
        directed_rows.push_back(tick_row(3'd0, 1'b1, 1'b1));
        directed_rows.push_back(tick_row(3'd3, 1'b1, 1'b0));
        directed_rows.push_back(tick_row(3'd7, 1'b1, 1'b1));
        directed_rows.push_back(tick_row(3'd0, 1'b1, 1'b0));
        directed_rows.push_back(zero_row(3'd5, 1'b0, 1'b0));
        directed_rows.push_back(tick_row(3'd5, 1'b1, 1'b0));
        directed_rows.push_back(write_row(sfsktg_pkg::REG_ALPHA, 32'h0000_FFFF));
        directed_rows.push_back(tick_row(3'd2, 1'b1, 1'b0));
        directed_rows.push_back(tick_row(3'd6, 1'b1, 1'b0));
        directed_rows.push_back(write_row(sfsktg_pkg::REG_ALPHA, 32'h0000_0000));
        directed_rows.push_back(tick_row(3'd1, 1'b1, 1'b0));
        directed_rows.push_back(write_row(sfsktg_pkg::REG_AMPLITUDE, 32'h0000_0000));
        directed_rows.push_back(zero_row(3'd4, 1'b1, 1'b1));
        directed_rows.push_back(zero_row(3'd4, 1'b1, 1'b0));
        directed_rows.push_back(write_row(sfsktg_pkg::REG_AMPLITUDE, 32'h0000_7FFF));
        directed_rows.push_back(write_row(sfsktg_pkg::REG_BASE_STEP, 32'h7FFF_FFFF));
        directed_rows.push_back(write_row(sfsktg_pkg::REG_TONE_STEP, 32'h0FFF_FFFF));
        directed_rows.push_back(tick_row(3'd7, 1'b1, 1'b1));
        directed_rows.push_back(tick_row(3'd7, 1'b1, 1'b0));
        directed_rows.push_back(tick_row(3'd0, 1'b1, 1'b0));
        directed_rows.push_back(write_row(sfsktg_pkg::REG_BASE_STEP, 32'h0000_0000));
        directed_rows.push_back(write_row(sfsktg_pkg::REG_TONE_STEP, 32'h0000_0000));
        directed_rows.push_back(write_row(sfsktg_pkg::REG_ALPHA, 32'hFFFF_FFFF));
        directed_rows.push_back(tick_row(3'd0, 1'b1, 1'b1));
        directed_rows.push_back(tick_row(3'd3, 1'b1, 1'b0));

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                program_register(directed_rows[i].reg_idx, directed_rows[i].wdata);
            end
            else
            begin
                send_tick(directed_rows[i].tone, directed_rows[i].active,
                          directed_rows[i].start, directed_rows[i].typed,
                          directed_rows[i].sample);
            end
        end

        // Random part: one register setting and idling pattern per set.
        for (int set_idx = 0; set_idx < SETTING_COUNT; set_idx++)
        begin
            case (set_idx % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 46; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 46; end
                default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
            endcase
            if (set_idx == 0)
            begin
                program_register(sfsktg_pkg::REG_BASE_STEP, 32'(sfsktg_pkg::BASE_STEP_RST));
                program_register(sfsktg_pkg::REG_TONE_STEP, 32'(sfsktg_pkg::TONE_STEP_RST));
                program_register(sfsktg_pkg::REG_ALPHA, 32'(sfsktg_pkg::ALPHA_RST));
                program_register(sfsktg_pkg::REG_AMPLITUDE, 32'(sfsktg_pkg::AMP_RST));
            end
            else
            begin
                program_register(sfsktg_pkg::REG_BASE_STEP, pick_reg_value());
                program_register(sfsktg_pkg::REG_TONE_STEP, pick_reg_value());
                program_register(sfsktg_pkg::REG_ALPHA, pick_reg_value());
                program_register(sfsktg_pkg::REG_AMPLITUDE, pick_reg_value());
            end

            counted = 0;
            while (counted < ITEMS_PER_SET)
            begin
                if ($urandom_range(99) < 15)
                begin
                    // Noise tick with every field random.
                    rnd_act = 1'($urandom_range(1));
                    rnd_tone = sfsktg_pkg::TONE_BITS'($urandom_range(7));
                    send_tick(rnd_tone, rnd_act, 1'($urandom_range(1)), 1'b0, '0);
                    counted += int'(rnd_act);
                end
                else
                begin
                    // One symbol: a start tick, then a run on the same tone,
                    // broken now and then by silence or a tone change.
                    sym_tone = sfsktg_pkg::TONE_BITS'($urandom_range(7));
                    run_len = int'($urandom_range(16, 1));
                    send_tick(sym_tone, 1'b1, 1'b1, 1'b0, '0);
                    counted++;
                    for (int j = 0; j < run_len; j++)
                    begin
                        roll = int'($urandom_range(99));
                        rnd_tone = sfsktg_pkg::TONE_BITS'($urandom_range(7));
                        if (roll < 6)
                        begin
                            send_tick(rnd_tone, 1'b0, 1'($urandom_range(1)), 1'b0, '0);
                        end
                        else if (roll < 12)
                        begin
                            send_tick(rnd_tone, 1'b1, 1'b0, 1'b0, '0);
                            counted++;
                        end
                        else
                        begin
                            send_tick(sym_tone, 1'b1, 1'b0, 1'b0, '0);
                            counted++;
                        end
                    end
                end
            end
        end

        // Let every sample come back, then watch for strays.
        drain_ticks();
        repeat (30) @(posedge clk);
        if (mismatch_count == 0 && pending_samples.size() == 0)
        begin
            $display("smoothed_fsk_tone_generator_core verification clean");
        end
        else
        begin
            $display("smoothed_fsk_tone_generator_core verification failed");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("smoothed_fsk_tone_generator_core verification failed");
        $finish;
    end

endmodule
